@@ design/pmsfp_pkg.sv @@
`timescale 1ns / 1ps

package pmsfp_pkg;

    // Field and state widths
    localparam int BYTE_W  = 8;
    localparam int WORD_W  = 16;
    localparam int COUNT_W = 8;

    // Default longest chunk; a chunk is closed at this length
    localparam int MAX_CHUNK_DEFAULT = 200;

    // Payload words sit at byte offsets 10, 12 and 14, big-endian
    localparam int PAYLOAD_OFFSET = 10;
    localparam int WORD_COUNT     = 3;
    localparam int PAYLOAD_END    = PAYLOAD_OFFSET + 2 * WORD_COUNT;

    // Register reset values
    localparam logic [BYTE_W-1:0] HEADER_FIRST_RESET  = 8'h42;
    localparam logic [BYTE_W-1:0] HEADER_SECOND_RESET = 8'h4D;
    localparam logic [BYTE_W-1:0] MIN_LENGTH_RESET    = 8'd10;

    // Configuration register indexes
    typedef enum logic [1:0] {
        CFG_HEADER_FIRST  = 2'd0,
        CFG_HEADER_SECOND = 2'd1,
        CFG_MIN_LENGTH    = 2'd2
    } cfg_idx_t;

    typedef struct packed {
        logic [BYTE_W-1:0] header_first;
        logic [BYTE_W-1:0] header_second;
        logic [BYTE_W-1:0] min_length;
    } cfg_t;

    // Index 0 is PM1.0, 1 is PM2.5, 2 is PM10
    typedef logic [WORD_COUNT-1:0][WORD_W-1:0] words_t;

    typedef struct packed {
        logic   close;
        logic   frame_ok;
        words_t readings;
    } result_t;

endpackage

@@ design/pmsfp_chunk_tracker.sv @@
`timescale 1ns / 1ps

module pmsfp_chunk_tracker #(
    parameter int MAX_CHUNK = pmsfp_pkg::MAX_CHUNK_DEFAULT
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          step,
    input  logic [pmsfp_pkg::BYTE_W-1:0]  rx_byte,
    input  logic                          chunk_end,
    input  pmsfp_pkg::cfg_t               cfg,
    output pmsfp_pkg::result_t            res,
    output pmsfp_pkg::words_t             held
);

    logic [pmsfp_pkg::COUNT_W-1:0] byte_count_reg;
    logic [pmsfp_pkg::WORD_W-1:0]  running_sum_reg;
    logic [pmsfp_pkg::BYTE_W-1:0]  last_byte_reg;
    logic                          header_match_reg;
    pmsfp_pkg::words_t             captured_reg;
    pmsfp_pkg::words_t             held_reg;

    logic                          header_match_next;
    pmsfp_pkg::words_t             captured_next;
    pmsfp_pkg::words_t             held_next;
    logic [pmsfp_pkg::COUNT_W:0]   len;
    logic [pmsfp_pkg::COUNT_W-1:0] rel;
    logic [1:0]                    word_sel;
    logic                          in_payload;
    logic [pmsfp_pkg::WORD_W-1:0]  chk;
    logic [pmsfp_pkg::WORD_W-1:0]  final_word;
    logic                          close;
    logic                          frame_ok;

    // Header check: a lone first byte compares the missing second byte as zero
    always_comb begin
        header_match_next = header_match_reg;
        if (byte_count_reg == '0) begin
            header_match_next = (rx_byte == cfg.header_first) && (cfg.header_second == '0);
        end else if (byte_count_reg == pmsfp_pkg::COUNT_W'(1)) begin
            header_match_next = (rx_byte == cfg.header_second)
                                && (last_byte_reg == cfg.header_first);
        end
    end

    // Payload word capture, high byte first
    assign in_payload = (byte_count_reg >= pmsfp_pkg::COUNT_W'(pmsfp_pkg::PAYLOAD_OFFSET))
                     && (byte_count_reg < pmsfp_pkg::COUNT_W'(pmsfp_pkg::PAYLOAD_END));
    assign rel        = byte_count_reg - pmsfp_pkg::COUNT_W'(pmsfp_pkg::PAYLOAD_OFFSET);
    assign word_sel   = rel[2:1];

    always_comb begin
        captured_next = captured_reg;
        if (in_payload) begin
            if (rel[0]) begin
                captured_next[word_sel][pmsfp_pkg::BYTE_W-1:0] = rx_byte;
            end else begin
                captured_next[word_sel][pmsfp_pkg::WORD_W-1:pmsfp_pkg::BYTE_W] = rx_byte;
            end
        end
    end

    // Close check: sum of all but the last two bytes against the final word
    assign len        = {1'b0, byte_count_reg} + (pmsfp_pkg::COUNT_W+1)'(1);
    assign close      = chunk_end || (len >= (pmsfp_pkg::COUNT_W+1)'(MAX_CHUNK));
    assign chk        = running_sum_reg - {{(pmsfp_pkg::WORD_W-pmsfp_pkg::BYTE_W){1'b0}},
                                           last_byte_reg};
    assign final_word = {last_byte_reg, rx_byte};
    assign frame_ok   = (len >= (pmsfp_pkg::COUNT_W+1)'(2))
                     && (len > {1'b0, cfg.min_length})
                     && header_match_next
                     && (chk == final_word);
    assign held_next  = frame_ok ? captured_next : held_reg;

    assign res.close    = close;
    assign res.frame_ok = frame_ok;
    assign res.readings = held_next;
    assign held         = held_reg;

    // Chunk state, cleared when the chunk closes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            byte_count_reg   <= '0;
            running_sum_reg  <= '0;
            last_byte_reg    <= '0;
            header_match_reg <= 1'b0;
            captured_reg     <= '0;
            held_reg         <= '0;
        end else if (step) begin
            if (close) begin
                byte_count_reg   <= '0;
                running_sum_reg  <= '0;
                last_byte_reg    <= '0;
                header_match_reg <= 1'b0;
                captured_reg     <= '0;
                held_reg         <= held_next;
            end else begin
                byte_count_reg   <= len[pmsfp_pkg::COUNT_W-1:0];
                running_sum_reg  <= running_sum_reg
                                  + {{(pmsfp_pkg::WORD_W-pmsfp_pkg::BYTE_W){1'b0}}, rx_byte};
                last_byte_reg    <= rx_byte;
                header_match_reg <= header_match_next;
                captured_reg     <= captured_next;
            end
        end
    end

`ifndef ASSERT_OFF
    // Count never reaches the forced close length
    a_count_below_max: assert property (@(posedge aclk) disable iff (!aresetn)
        byte_count_reg < pmsfp_pkg::COUNT_W'(MAX_CHUNK))
        else $error("byte count reached maximum chunk length");

    // A closing byte starts the next chunk from scratch
    a_close_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        step && close |=> byte_count_reg == '0 && running_sum_reg == '0
                          && captured_reg == '0)
        else $error("chunk state not cleared after close");

    // Held readings change only on a passing close
    a_held_only_on_ok: assert property (@(posedge aclk) disable iff (!aresetn)
        !(step && close && frame_ok) |=> $stable(held_reg))
        else $error("held readings changed without a passing chunk");
`endif

endmodule

@@ design/pm_sensor_frame_parser_top.sv @@
`timescale 1ns / 1ps

// Particulate-sensor frame parser. Bytes of a received chunk arrive one per
// transfer on the s_ channel, with s_tlast on the chunk's last byte; a chunk that
// reaches MAX_CHUNK bytes is closed on that byte. Each closed chunk yields one
// transfer on the m_ channel carrying the held PM1.0, PM2.5 and PM10 readings and
// a pass flag in m_tuser; the readings are replaced only when the chunk passes the
// length, header and checksum checks. The block takes one byte per clock cycle
// while m_ is not stalled: each byte goes through an input register, compare and
// add logic, and an output register, so the closing byte's result is registered
// in the output register, which drives m_tvalid. Stalls on m_ back up to s_tready.
// Configuration writes apply from the next byte on and should be made while no
// chunk is in progress.
module pm_sensor_frame_parser_top #(
    parameter int MAX_CHUNK = pmsfp_pkg::MAX_CHUNK_DEFAULT
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    // Configuration write port
    input  logic                          cfg_wr_en,
    input  logic [1:0]                    cfg_addr,
    input  logic [pmsfp_pkg::BYTE_W-1:0]  cfg_wdata,
    // Received bytes
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [7:0]                    s_tdata,   // [7:0] rx_byte
    input  logic                          s_tlast,   // chunk_end
    // Results
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [47:0]                   m_tdata,   // [15:0] pm1, [31:16] pm25, [47:32] pm10
    output logic                          m_tuser    // frame_ok
);

    pmsfp_pkg::cfg_t     cfg_reg;
    logic                in_valid_reg;
    logic [7:0]          in_byte_reg;
    logic                in_last_reg;
    logic                out_valid_reg;
    logic                out_valid_next;
    logic                out_ok_reg;
    pmsfp_pkg::words_t   out_words_reg;
    logic                advance;
    pmsfp_pkg::result_t  res;
    pmsfp_pkg::words_t   held;

    // Configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.header_first  <= pmsfp_pkg::HEADER_FIRST_RESET;
            cfg_reg.header_second <= pmsfp_pkg::HEADER_SECOND_RESET;
            cfg_reg.min_length    <= pmsfp_pkg::MIN_LENGTH_RESET;
        end else if (cfg_wr_en) begin
            unique case (cfg_addr)
                pmsfp_pkg::CFG_HEADER_FIRST:  cfg_reg.header_first  <= cfg_wdata;
                pmsfp_pkg::CFG_HEADER_SECOND: cfg_reg.header_second <= cfg_wdata;
                pmsfp_pkg::CFG_MIN_LENGTH:    cfg_reg.min_length    <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // Stage advances when the output register is free or draining
    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;

    // Input register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_byte_reg <= s_tdata;
            in_last_reg <= s_tlast;
        end
    end

    pmsfp_chunk_tracker #(
        .MAX_CHUNK (MAX_CHUNK)
    ) u_tracker (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .step      (advance),
        .rx_byte   (in_byte_reg),
        .chunk_end (in_last_reg),
        .cfg       (cfg_reg),
        .res       (res),
        .held      (held)
    );

    // Output register
    always_comb begin
        out_valid_next = out_valid_reg;
        if (!out_valid_reg || m_tready) begin
            out_valid_next = advance && res.close;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance && res.close) begin
            out_ok_reg    <= res.frame_ok;
            out_words_reg <= res.readings;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_ok_reg;
    assign m_tdata  = {out_words_reg[2], out_words_reg[1], out_words_reg[0]};

`ifndef ASSERT_OFF
    // No byte is consumed while a result waits on a stalled sink
    a_no_advance_on_stall: assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid_reg && !m_tready |-> !advance)
        else $error("byte consumed while result stalled");

    // Every closing byte produces a result
    a_close_gives_result: assert property (@(posedge aclk) disable iff (!aresetn)
        advance && res.close |=> out_valid_reg)
        else $error("closed chunk produced no result");

    // A pending result always shows the currently held readings
    a_result_matches_held: assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid_reg |-> out_words_reg == held)
        else $error("result readings differ from held readings");
`endif

endmodule
